// ===== rtl/length_prefixed_message_ring_buffer_macros.svh =====
`ifndef LENGTH_PREFIXED_MESSAGE_RING_BUFFER_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_BUFFER_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define LPMRB_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define LPMRB_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lpmrb_pkg.sv =====
`default_nettype none
package lpmrb_pkg;

  localparam int DEF_BUFFER_BYTES = 1024;
  localparam int MAX_PAYLOAD = 62;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_SINGLE = 2'd2;
  localparam logic [1:0] OP_PACKED = 2'd3;

  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd2;
  localparam logic [1:0] STATUS_CORRUPT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  message_length;
    logic [7:0]  data_byte;
    logic [15:0] capacity;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
    logic [5:0] bytes_taken;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEADER,
    ST_STREAM
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_EMPTY,
    EMIT_CORRUPT,
    EMIT_NO_ROOM,
    EMIT_HEADER,
    EMIT_ZERO,
    EMIT_DATA
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  clear;
    logic  hdr_take;
    logic  step;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic hdr_bad;
    logic no_room;
    logic payload_zero;
    logic packed_mode;
    logic count_one;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/lpmrb_ctrl.sv =====
`default_nettype none
`include "length_prefixed_message_ring_buffer_macros.svh"
module lpmrb_ctrl
  import lpmrb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] operation,
  input  wire ctrl_sts_t  sts,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{load: 1'b0, clear: 1'b0, hdr_take: 1'b0, step: 1'b0, emit: EMIT_NONE};
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (operation == OP_SINGLE || operation == OP_PACKED) begin
            state_next = ST_HEADER;
          end
        end
      end
      ST_HEADER: begin
        state_next = ST_IDLE;
        if (sts.empty) begin
          cmd.emit = EMIT_EMPTY;
        end else if (sts.hdr_bad) begin
          cmd.clear = 1'b1;
          cmd.emit = EMIT_CORRUPT;
        end else if (sts.no_room) begin
          cmd.emit = EMIT_NO_ROOM;
        end else begin
          cmd.hdr_take = 1'b1;
          if (sts.packed_mode) begin
            cmd.emit = EMIT_HEADER;
          end else if (sts.payload_zero) begin
            cmd.emit = EMIT_ZERO;
          end
          if (!sts.payload_zero) begin
            state_next = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        cmd.step = 1'b1;
        cmd.emit = EMIT_DATA;
        if (sts.count_one) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `LPMRB_ASSERT_NEXT(a_header_one_cycle, state == ST_HEADER, state != ST_HEADER, "header check held")
  `LPMRB_ASSERT_NEXT(a_read_to_header, !busy && start && operation[1], state == ST_HEADER, "read not started")
  `LPMRB_ASSERT_NOW(a_clear_only_in_header, cmd.clear, state == ST_HEADER && !cmd.hdr_take, "stray clear")

endmodule
`default_nettype wire

// ===== rtl/lpmrb_dp.sv =====
`default_nettype none
`include "length_prefixed_message_ring_buffer_macros.svh"
module lpmrb_dp
  import lpmrb_pkg::*;
#(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      request,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts,
  output logic           strobe,
  output rsp_t           result
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] rp;
  logic [AW-1:0] rp_next;
  logic [AW-1:0] wp;
  logic [5:0]    left;
  logic [5:0]    header;
  logic [5:0]    count;
  logic [15:0]   cap;
  logic          packed_mode;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          begin_ok;
  logic          data_ok;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    if (p == AW'(BUFFER_BYTES - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign begin_ok = cmd.load && request.operation == OP_BEGIN &&
                    request.message_length != 6'd0 &&
                    request.message_length <= 6'(MAX_PAYLOAD);
  assign data_ok = cmd.load && request.operation == OP_DATA && left != 6'd0;
  assign mem_we = begin_ok || data_ok;
  assign mem_wdata = begin_ok ? ({2'b00, request.message_length} + 8'd1) : request.data_byte;

  always_comb begin
    rp_next = rp;
    if (cmd.clear) begin
      rp_next = '0;
    end else if (cmd.hdr_take || cmd.step) begin
      rp_next = adv(rp);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= mem_wdata;
    end
    rd_data <= mem[rp_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
      left <= '0;
    end else begin
      rp <= rp_next;
      if (cmd.clear) begin
        wp <= '0;
      end else if (mem_we) begin
        wp <= adv(wp);
      end
      if (begin_ok) begin
        left <= request.message_length;
      end else if (data_ok) begin
        left <= left - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap <= request.capacity;
      packed_mode <= (request.operation == OP_PACKED);
    end
    if (cmd.hdr_take) begin
      header <= rd_data[5:0];
      count <= rd_data[5:0] - 6'd1;
    end else if (cmd.step) begin
      count <= count - 6'd1;
    end
  end

  assign sts.empty = (rp == wp);
  assign sts.hdr_bad = (rd_data == 8'd0) || (rd_data > 8'(MAX_PAYLOAD + 1));
  assign sts.no_room = ({8'd0, rd_data} > cap);
  assign sts.payload_zero = (rd_data == 8'd1);
  assign sts.packed_mode = packed_mode;
  assign sts.count_one = (count == 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_EMPTY: result <= '{out_byte: 8'd0, last: 1'b1, status: STATUS_EMPTY,
                              bytes_taken: 6'd0};
      EMIT_CORRUPT: result <= '{out_byte: 8'd0, last: 1'b1, status: STATUS_CORRUPT,
                                bytes_taken: 6'd0};
      EMIT_NO_ROOM: result <= '{out_byte: 8'd0, last: 1'b1, status: STATUS_NO_ROOM,
                                bytes_taken: 6'd0};
      EMIT_HEADER: result <= '{out_byte: rd_data, last: (rd_data == 8'd1),
                               status: STATUS_DATA, bytes_taken: rd_data[5:0]};
      EMIT_ZERO: result <= '{out_byte: 8'd0, last: 1'b1, status: STATUS_DATA,
                             bytes_taken: 6'd0};
      EMIT_DATA: result <= '{out_byte: rd_data, last: (count == 6'd1),
                             status: STATUS_DATA,
                             bytes_taken: packed_mode ? header : header - 6'd1};
      default: result <= result;
    endcase
  end

  `LPMRB_ASSERT_NEXT(a_clear_ptrs, cmd.clear, rp == '0 && wp == '0, "pointers not cleared")
  `LPMRB_ASSERT_NEXT(a_stream_last, cmd.emit == EMIT_DATA && count == 6'd1, strobe && result.last, "last missing")
  `LPMRB_ASSERT_NOW(a_err_last, strobe && result.status != STATUS_DATA, result.last && result.bytes_taken == 6'd0, "bad error result")

endmodule
`default_nettype wire

// ===== rtl/length_prefixed_message_ring_buffer.sv =====
// write items produce no result and leave busy low
// a read fetches and checks the header, then streams one byte per cycle from the store
// read port; results are registered and shown one per cycle, in the cycle after they are
// formed, and the receiver cannot stall. busy is low again as the last result is shown.
// synchronous reset clears both ring pointers and the pending payload count;
// store contents are undefined until written
`default_nettype none
module length_prefixed_message_ring_buffer
  import lpmrb_pkg::*;
#(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output logic      strobe,
  output rsp_t      result
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lpmrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  lpmrb_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .strobe  (strobe),
    .result  (result)
  );

endmodule
`default_nettype wire

// ===== tb/tb_length_prefixed_message_ring_buffer.sv =====
`timescale 1ns / 1ps
module tb_length_prefixed_message_ring_buffer;
  import lpmrb_pkg::*;

  localparam int RING_BYTES = DEF_BUFFER_BYTES;
  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_EVERY = 125;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic hold;
    req_t req;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic strobe;
  rsp_t result;

  // index 0 tracks accepted transfers, index 1 tracks the stimulus as it is built
  logic [7:0] ring_mem [2][RING_BYTES];
  bit ring_seen [2][RING_BYTES];
  int unsigned ring_rd [2];
  int unsigned ring_wr [2];
  int unsigned ring_left [2];

  pending_t pending_requests[$];
  rsp_t expected_readout[$];
  rsp_t want;
  bit hold_next = 1'b0;
  int n_effective = 0;
  int gap_left = 0;
  int errors = 0;
  int cycles = 0;
  int n_reads = 0;
  int n_results = 0;
  int n_empty = 0;
  int n_no_room = 0;
  int n_corrupt = 0;

  length_prefixed_message_ring_buffer #(
    .BUFFER_BYTES(RING_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1) % RING_BYTES;
  endfunction

  function automatic void note_result(input int m, input logic [7:0] b, input logic l,
                                      input logic [1:0] s, input logic [5:0] t);
    if (m == 0) expected_readout.push_back('{out_byte: b, last: l, status: s, bytes_taken: t});
  endfunction

  function automatic void apply_to_ring(input int m, input req_t q);
    logic [7:0] hdr;
    int unsigned pay;
    bit pk;
    pk = (q.operation == OP_PACKED);
    case (q.operation)
      OP_BEGIN: begin
        if (q.message_length != 0 && q.message_length <= MAX_PAYLOAD) begin
          ring_mem[m][ring_wr[m]] = q.message_length + 8'd1;
          ring_seen[m][ring_wr[m]] = 1'b1;
          ring_wr[m] = ring_next(ring_wr[m]);
          ring_left[m] = 32'(q.message_length);
        end
      end
      OP_DATA: begin
        if (ring_left[m] != 0) begin
          ring_mem[m][ring_wr[m]] = q.data_byte;
          ring_seen[m][ring_wr[m]] = 1'b1;
          ring_wr[m] = ring_next(ring_wr[m]);
          ring_left[m]--;
        end
      end
      default: begin
        if (ring_rd[m] == ring_wr[m]) begin
          note_result(m, 8'd0, 1'b1, STATUS_EMPTY, 6'd0);
        end else begin
          hdr = ring_mem[m][ring_rd[m]];
          if (hdr == 8'd0 || hdr > MAX_PAYLOAD + 1) begin
            ring_rd[m] = 0;
            ring_wr[m] = 0;
            note_result(m, 8'd0, 1'b1, STATUS_CORRUPT, 6'd0);
          end else if (hdr > q.capacity) begin
            note_result(m, 8'd0, 1'b1, STATUS_NO_ROOM, 6'd0);
          end else begin
            pay = hdr - 1;
            ring_rd[m] = ring_next(ring_rd[m]);
            if (pk) note_result(m, hdr, pay == 0, STATUS_DATA, hdr[5:0]);
            else if (pay == 0) note_result(m, 8'd0, 1'b1, STATUS_DATA, 6'd0);
            for (int i = 0; i < pay; i++) begin
              note_result(m, ring_mem[m][ring_rd[m]], i + 1 == pay, STATUS_DATA,
                          pk ? hdr[5:0] : 6'(pay));
              ring_rd[m] = ring_next(ring_rd[m]);
            end
          end
        end
      end
    endcase
  endfunction

  // a read must never touch a store entry that was never written
  function automatic bit read_is_defined(input logic [15:0] cap);
    int unsigned p;
    logic [7:0] hdr;
    p = ring_rd[1];
    if (p == ring_wr[1]) return 1'b1;
    if (!ring_seen[1][p]) return 1'b0;
    hdr = ring_mem[1][p];
    if (hdr == 8'd0 || hdr > MAX_PAYLOAD + 1 || hdr > cap) return 1'b1;
    for (int i = 1; i < hdr; i++) begin
      p = ring_next(p);
      if (!ring_seen[1][p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_op(input logic [1:0] op, input logic [5:0] len,
                                 input logic [7:0] data, input logic [15:0] cap);
    req_t q;
    bit rd_op;
    q = '{operation: op, message_length: len, data_byte: data, capacity: cap};
    rd_op = (op == OP_SINGLE || op == OP_PACKED);
    if (rd_op && !read_is_defined(cap)) return;
    if (rd_op || (op == OP_BEGIN && len != 0 && len <= MAX_PAYLOAD) ||
        (op == OP_DATA && ring_left[1] != 0)) n_effective++;
    apply_to_ring(1, q);
    pending_requests.push_back('{hold: hold_next, req: q});
    hold_next = 1'b0;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        apply_to_ring(0, request);
        if (request.operation == OP_SINGLE || request.operation == OP_PACKED) n_reads++;
        void'(pending_requests.pop_front());
        gap_left = pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() != 0 &&
                     (!pending_requests[0].hold || expected_readout.size() == 0)) begin
          start <= 1'b1;
          request <= pending_requests[0].req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      n_results++;
      case (result.status)
        STATUS_EMPTY: n_empty++;
        STATUS_NO_ROOM: n_no_room++;
        STATUS_CORRUPT: n_corrupt++;
        default: ;
      endcase
      if (expected_readout.size() == 0) begin
        $display("%0t: unexpected result byte %02h last %0d status %0d taken %0d", $time,
                 result.out_byte, result.last, result.status, result.bytes_taken);
        errors++;
      end else begin
        want = expected_readout.pop_front();
        if (result !== want) begin
          $display("%0t: mismatch expected byte %02h last %0d status %0d taken %0d", $time,
                   want.out_byte, want.last, want.status, want.bytes_taken);
          $display("%0t:          actual   byte %02h last %0d status %0d taken %0d", $time,
                   result.out_byte, result.last, result.status, result.bytes_taken);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d requests and %0d results outstanding", $time,
               pending_requests.size(), expected_readout.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int waited;
    int sel;
    int len;
    int cut;
    int next_hold;
    logic [7:0] hdr;
    logic [15:0] cap;

    // empty ring, ignored lengths, stray data
    add_op(OP_SINGLE, 6'd0, 8'd0, 16'd0);
    add_op(OP_BEGIN, 6'd0, 8'h11, 16'hFFFF);
    add_op(OP_BEGIN, 6'd63, 8'h22, 16'hFFFF);
    add_op(OP_DATA, 6'd5, 8'hAA, 16'h0);
    // plain message
    add_op(OP_BEGIN, 6'd3, 8'h0, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h00, 16'h0);
    add_op(OP_DATA, 6'd0, 8'hFF, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h5A, 16'h0);
    add_op(OP_SINGLE, 6'd0, 8'h0, 16'd4);
    // abandoned message leaves a header of one for packed mode
    add_op(OP_BEGIN, 6'd2, 8'h0, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h01, 16'h0);
    add_op(OP_BEGIN, 6'd1, 8'h0, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h01, 16'h0);
    add_op(OP_SINGLE, 6'd0, 8'h0, 16'd3);
    add_op(OP_PACKED, 6'd0, 8'h0, 16'd1);
    // header of one in single mode, zero room, then a zero header
    add_op(OP_BEGIN, 6'd2, 8'h0, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h01, 16'h0);
    add_op(OP_BEGIN, 6'd2, 8'h0, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h01, 16'h0);
    add_op(OP_DATA, 6'd0, 8'h00, 16'h0);
    add_op(OP_SINGLE, 6'd0, 8'h0, 16'hFFFF);
    add_op(OP_SINGLE, 6'd0, 8'h0, 16'd0);
    add_op(OP_SINGLE, 6'd0, 8'h0, 16'd1);
    add_op(OP_PACKED, 6'd0, 8'h0, 16'hFFFF);
    // after the pointer reset, read ahead of the writer into old bytes
    add_op(OP_BEGIN, 6'd3, 8'h0, 16'h0);
    add_op(OP_SINGLE, 6'd0, 8'h0, 16'hFFFF);

    n_effective = 0;
    next_hold = 0;
    while (n_effective < RANDOM_ITEMS) begin
      if (n_effective >= next_hold) begin
        hold_next = 1'b1;
        next_hold += HOLD_EVERY;
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 9))
          0: len = MAX_PAYLOAD;
          1: len = $urandom_range(20, MAX_PAYLOAD);
          default: len = $urandom_range(1, 8);
        endcase
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
        add_op(OP_BEGIN, 6'(len), 8'($urandom), 16'($urandom));
        for (int i = 0; i < cut; i++) add_op(OP_DATA, 6'($urandom), 8'($urandom), 16'($urandom));
      end else if (sel < 90) begin
        hdr = ring_seen[1][ring_rd[1]] ? ring_mem[1][ring_rd[1]] : 8'd0;
        case ($urandom_range(0, 5))
          0: cap = 16'hFFFF;
          1: cap = 16'($urandom);
          2: cap = 16'(hdr);
          3: cap = 16'(hdr) - 16'd1;
          4: cap = 16'($urandom_range(0, 70));
          default: cap = 16'(hdr) + 16'($urandom_range(0, 3));
        endcase
        add_op($urandom_range(0, 1) ? OP_PACKED : OP_SINGLE, 6'($urandom), 8'($urandom), cap);
      end else begin
        case ($urandom_range(0, 2))
          0: len = 0;
          1: len = 63;
          default: len = $urandom_range(0, 63);
        endcase
        add_op(2'($urandom), 6'(len), 8'($urandom), 16'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_requests.size() != 0 || start) @(posedge clk);
    waited = 0;
    while (expected_readout.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_readout.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_readout.size());
      errors++;
    end
    $display("run: %0d reads, %0d results checked (%0d empty, %0d no room, %0d corrupt)",
             n_reads, n_results, n_empty, n_no_room, n_corrupt);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
